// ===== rtl/core/uifc_pkg.sv =====
package uifc_pkg;

  localparam int FrameBytes = 8;
  localparam int Slots      = 256;
  localparam int CntW       = $clog2(FrameBytes + 1);
  localparam int IdxW       = $clog2(FrameBytes);
  localparam int LenW       = 3;
  localparam int SlotW      = 8;

  localparam logic OpByte = 1'b0;
  localparam logic OpIdle = 1'b1;

  localparam logic KindPayload = 1'b0;
  localparam logic KindStatus  = 1'b1;

  typedef enum logic [1:0] {
    StOk    = 2'd0,
    StBad   = 2'd1,
    StEmpty = 2'd2,
    StLong  = 2'd3
  } status_e;

  // one closed frame, as handed from the front to the back
  typedef struct packed {
    status_e          status;
    logic [LenW-1:0]  length;
    logic [SlotW-1:0] slot;
    logic             ready_res;
    logic [LenW-1:0]  npay;
  } cmd_t;

  typedef struct packed {
    logic            pay_done;
    logic [IdxW-1:0] rd_idx;
  } back_ctl_t;

endpackage

// ===== rtl/core/uifc_if.sv =====
interface uifc_in_if;
  logic       valid;
  logic       ready;
  logic       operation;
  logic [7:0] data_byte;

  modport source (output valid, output operation, output data_byte, input ready);
  modport sink   (input valid, input operation, input data_byte, output ready);
endinterface

interface uifc_out_if;
  logic       valid;
  logic       ready;
  logic       kind;
  logic [7:0] payload;
  logic [7:0] slot;
  logic [2:0] length;
  logic [1:0] status;
  logic       ready_res;
  logic       last;

  modport source (output valid, output kind, output payload, output slot, output length,
                  output status, output ready_res, output last, input ready);
  modport sink   (input valid, input kind, input payload, input slot, input length,
                  input status, input ready_res, input last, output ready);
endinterface

// ===== rtl/core/uifc_front.sv =====
module uifc_front (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  uifc_in_if.sink               rx_i,
  input  logic                  q_full_i,
  output logic                  q_push_o,
  output uifc_pkg::cmd_t        q_cmd_o,
  input  uifc_pkg::back_ctl_t   back_i,
  output logic [7:0]            rd_data_o
);

  logic [7:0]                  store_q [uifc_pkg::FrameBytes];
  logic [7:0]                  rd_data_q;
  logic [uifc_pkg::CntW-1:0]   count_q, count_d;
  logic                        overlong_q, overlong_d;
  logic [uifc_pkg::SlotW-1:0]  slot_q, slot_d;
  logic                        ready_q, ready_d;
  logic [7:0]                  sum_q, sum_d;
  logic [7:0]                  last_q, last_d;
  logic                        pend_q, pend_d;

  logic                        accept;
  logic                        is_byte;
  logic                        has_room;
  logic [7:0]                  head_sum;
  logic [uifc_pkg::LenW-1:0]   len;
  uifc_pkg::cmd_t              cmd;

  // bytes wait while an accepted frame is still being read out
  assign rx_i.ready = (rx_i.operation == uifc_pkg::OpIdle) ? !q_full_i : !pend_q;
  assign accept     = rx_i.valid && rx_i.ready;
  assign is_byte    = rx_i.operation == uifc_pkg::OpByte;
  assign has_room   = count_q < uifc_pkg::CntW'(uifc_pkg::FrameBytes);
  assign head_sum   = sum_q - last_q;
  assign len        = uifc_pkg::LenW'(count_q - uifc_pkg::CntW'(1));
  assign rd_data_o  = rd_data_q;

  always_comb begin
    cmd           = '0;
    cmd.slot      = slot_q;
    cmd.ready_res = ready_q;
    priority if (overlong_q) begin
      cmd.status = uifc_pkg::StLong;
    end else if (count_q == '0) begin
      cmd.status = uifc_pkg::StEmpty;
    end else if (head_sum == last_q) begin
      cmd.status    = uifc_pkg::StOk;
      cmd.length    = len;
      cmd.npay      = len;
      cmd.ready_res = 1'b1;
    end else begin
      cmd.status = uifc_pkg::StBad;
      cmd.length = len;
    end
  end

  assign q_push_o = accept && !is_byte;
  assign q_cmd_o  = cmd;

  always_comb begin
    count_d    = count_q;
    overlong_d = overlong_q;
    slot_d     = slot_q;
    ready_d    = ready_q;
    sum_d      = sum_q;
    last_d     = last_q;
    pend_d     = pend_q;
    if (back_i.pay_done) begin
      pend_d = 1'b0;
    end
    if (accept) begin
      if (is_byte) begin
        ready_d = 1'b0;
        if (has_room) begin
          count_d = count_q + uifc_pkg::CntW'(1);
          sum_d   = sum_q + rx_i.data_byte;
          last_d  = rx_i.data_byte;
        end else begin
          overlong_d = 1'b1;
        end
      end else begin
        if (cmd.status == uifc_pkg::StOk && !overlong_q && count_q != '0) begin
          ready_d = 1'b1;
          slot_d  = (slot_q == uifc_pkg::SlotW'(uifc_pkg::Slots - 1)) ? '0
                                                                     : slot_q + 1'b1;
          if (len != '0) begin
            pend_d = 1'b1;
          end
        end
        count_d    = '0;
        overlong_d = 1'b0;
        sum_d      = '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q    <= '0;
      overlong_q <= 1'b0;
      slot_q     <= '0;
      ready_q    <= 1'b0;
      sum_q      <= '0;
      last_q     <= '0;
      pend_q     <= 1'b0;
    end else begin
      count_q    <= count_d;
      overlong_q <= overlong_d;
      slot_q     <= slot_d;
      ready_q    <= ready_d;
      sum_q      <= sum_d;
      last_q     <= last_d;
      pend_q     <= pend_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept && is_byte && has_room) begin
      store_q[count_q[uifc_pkg::IdxW-1:0]] <= rx_i.data_byte;
    end
    rd_data_q <= store_q[back_i.rd_idx];
  end

endmodule

// ===== rtl/core/uifc_fifo.sv =====
module uifc_fifo (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  uifc_pkg::cmd_t data_i,
  output logic           full_o,
  input  logic           pop_i,
  output uifc_pkg::cmd_t data_o,
  output logic           empty_o
);

  uifc_pkg::cmd_t mem_q [2];
  logic           wr_q, rd_q;
  logic [1:0]     cnt_q;

  assign full_o  = cnt_q == 2'd2;
  assign empty_o = cnt_q == 2'd0;
  assign data_o  = mem_q[rd_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= '0;
    end else begin
      if (push_i) begin
        wr_q <= !wr_q;
      end
      if (pop_i) begin
        rd_q <= !rd_q;
      end
      unique case ({push_i, pop_i})
        2'b10:   cnt_q <= cnt_q + 2'd1;
        2'b01:   cnt_q <= cnt_q - 2'd1;
        default: cnt_q <= cnt_q;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= data_i;
    end
  end

endmodule

// ===== rtl/core/uifc_back.sv =====
module uifc_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                q_empty_i,
  input  uifc_pkg::cmd_t      q_cmd_i,
  output logic                q_pop_o,
  output uifc_pkg::back_ctl_t ctl_o,
  input  logic [7:0]          rd_data_i,
  uifc_out_if.source          res_o
);

  logic                      busy_q;
  uifc_pkg::cmd_t            cmd_q;
  logic [uifc_pkg::IdxW-1:0] idx_q, idx_d;

  logic       out_valid_q;
  logic       kind_q;
  logic [7:0] payload_q;
  logic [7:0] slot_q;
  logic [2:0] length_q;
  logic [1:0] status_q;
  logic       ready_res_q;
  logic       last_q;

  logic emit;
  logic pay_step;

  assign q_pop_o  = !busy_q && !q_empty_i;
  assign emit     = busy_q && (!out_valid_q || res_o.ready);
  assign pay_step = uifc_pkg::LenW'(idx_q) < cmd_q.npay;

  // store read is registered, so it is addressed with the next index
  always_comb begin
    idx_d = idx_q;
    if (q_pop_o) begin
      idx_d = '0;
    end else if (emit && pay_step) begin
      idx_d = idx_q + 1'b1;
    end
  end

  assign ctl_o.rd_idx   = idx_d;
  assign ctl_o.pay_done = emit && !pay_step && cmd_q.npay != '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      idx_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      idx_q <= idx_d;
      if (q_pop_o) begin
        busy_q <= 1'b1;
      end else if (emit && !pay_step) begin
        busy_q <= 1'b0;
      end
      if (emit) begin
        out_valid_q <= 1'b1;
      end else if (res_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (q_pop_o) begin
      cmd_q <= q_cmd_i;
    end
    if (emit) begin
      slot_q      <= cmd_q.slot;
      length_q    <= cmd_q.length;
      status_q    <= cmd_q.status;
      ready_res_q <= cmd_q.ready_res;
      if (pay_step) begin
        kind_q    <= uifc_pkg::KindPayload;
        payload_q <= rd_data_i;
        last_q    <= 1'b0;
      end else begin
        kind_q    <= uifc_pkg::KindStatus;
        payload_q <= '0;
        last_q    <= 1'b1;
      end
    end
  end

  assign res_o.valid     = out_valid_q;
  assign res_o.kind      = kind_q;
  assign res_o.payload   = payload_q;
  assign res_o.slot      = slot_q;
  assign res_o.length    = length_q;
  assign res_o.status    = status_q;
  assign res_o.ready_res = ready_res_q;
  assign res_o.last      = last_q;

endmodule

// ===== rtl/core/uart_idle_frame_checksum_receiver.sv =====
// Frame receiver for UART bytes closed by an idle-line event. Each byte beat
// emits nothing; the last byte of a frame is the 8-bit wrapping sum of the
// bytes before it. An idle beat queues one command in the front part
// (two-entry queue); the back part then loads it and emits one result item
// after another: len payload beats and a status beat, last set, for a good
// frame, and one status beat for a bad, empty or overlong frame. The back
// part's single output register sets the emit rate of one item per cycle
// while res_o.ready does not stall it. Byte beats are held off while a good
// frame's payload is still being read from the frame store; idle beats are
// held off only while the queue is full.
module uart_idle_frame_checksum_receiver (
  input  logic       clk_i,
  input  logic       rst_ni,
  uifc_in_if.sink    rx_i,
  uifc_out_if.source res_o
);

  logic                q_push;
  logic                q_pop;
  logic                q_full;
  logic                q_empty;
  uifc_pkg::cmd_t      q_wr_cmd;
  uifc_pkg::cmd_t      q_rd_cmd;
  uifc_pkg::back_ctl_t back_ctl;
  logic [7:0]          rd_data;

  uifc_front u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .rx_i      (rx_i),
    .q_full_i  (q_full),
    .q_push_o  (q_push),
    .q_cmd_o   (q_wr_cmd),
    .back_i    (back_ctl),
    .rd_data_o (rd_data)
  );

  uifc_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .data_i  (q_wr_cmd),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .data_o  (q_rd_cmd),
    .empty_o (q_empty)
  );

  uifc_back u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .q_empty_i (q_empty),
    .q_cmd_i   (q_rd_cmd),
    .q_pop_o   (q_pop),
    .ctl_o     (back_ctl),
    .rd_data_i (rd_data),
    .res_o     (res_o)
  );

endmodule
